@@ hw/rtl/lcor_pkg.sv @@
// ----------------------------------------------------------------------------
// lcor_pkg
// Shared types and constants of the two-sided bounded-lag correlator.
// ----------------------------------------------------------------------------
package lcor_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int ACC_W    = 48;
    localparam int LAG_W    = 6;
    localparam logic [LAG_W-1:0] LAG_RESET = LAG_W'(15);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic [LAG_W-1:0]           lag_t;

    localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic take;
        logic flush;
        logic accum;
        logic shift;
        logic clear;
    } ctl_t;

    typedef enum logic {
        ST_RUN,
        ST_DRAIN
    } state_t;

endpackage

@@ hw/rtl/lcor_if.sv @@
// ----------------------------------------------------------------------------
// lcor_if
// Channel interfaces for sample pairs, results and the lag register.
// ----------------------------------------------------------------------------
interface lcor_in_if;
    logic             valid;
    logic             ready;
    lcor_pkg::sample_t a_sample;
    lcor_pkg::sample_t b_sample;
    logic             last_in;

    modport source (output valid, a_sample, b_sample, last_in, input ready);
    modport sink   (input valid, a_sample, b_sample, last_in, output ready);
endinterface

interface lcor_out_if;
    logic           valid;
    logic           ready;
    lcor_pkg::lag_t lag;
    lcor_pkg::acc_t pos_sum;
    lcor_pkg::acc_t neg_sum;
    logic           last_out;

    modport source (output valid, lag, pos_sum, neg_sum, last_out, input ready);
    modport sink   (input valid, lag, pos_sum, neg_sum, last_out, output ready);
endinterface

interface lcor_cfg_if;
    logic           valid;
    logic           ready;
    lcor_pkg::lag_t max_lag;

    modport source (output valid, max_lag, input ready);
    modport sink   (input valid, max_lag, output ready);
endinterface

@@ hw/rtl/two_sided_lag_correlator_top.sv @@
// ----------------------------------------------------------------------------
// two_sided_lag_correlator_top
// Streaming cross correlator over lags 0 to MAX_LAG in both directions,
// built as a row of multiply-accumulate cells fed by a sample delay line.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transaction
//  in_ch     sink       one sample pair a_sample, b_sample with last_in
//  out_ch    source     one result lag, pos_sum, neg_sum, last_out
//  cfg_ch    sink       write of max_lag, always ready
//
//  A sample pair is taken every cycle while no sequence is being unloaded.
//  The results of a sequence start once its last pair has passed through the
//  product register and the accumulator, and leave at one per cycle while
//  out_ch is ready, min(max_lag, MAX_LAG)+1 of them, lag zero first.
//  in_ch is held off from the last pair until the final result is taken.
//  A stall on out_ch holds the current result. Reset clears all sums.
// ----------------------------------------------------------------------------
module two_sided_lag_correlator_top #(
    parameter int MAX_LAG = 63
) (
    input  logic        clk,
    input  logic        rst_n,
    lcor_in_if.sink     in_ch,
    lcor_out_if.source  out_ch,
    lcor_cfg_if.sink    cfg_ch
);
    import lcor_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    lag_t    max_lag_reg;
    lag_t    lag_cnt_reg;
    lag_t    lag_cnt_next;
    lag_t    top_lag;
    logic    prod_vld_reg;
    logic    prod_last_reg;
    logic    in_fire;
    logic    out_fire;
    logic    drain_done;
    ctl_t    ctl;

    sample_t a_chain [0:MAX_LAG];
    sample_t b_chain [0:MAX_LAG];
    acc_t    pos_chain [0:MAX_LAG+1];
    acc_t    neg_chain [0:MAX_LAG+1];

    assign top_lag    = (max_lag_reg > LAG_W'(MAX_LAG)) ? LAG_W'(MAX_LAG) : max_lag_reg;
    assign in_fire    = in_ch.valid && in_ch.ready;
    assign out_fire   = out_ch.valid && out_ch.ready;
    assign drain_done = out_fire && (lag_cnt_reg == top_lag);

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_lag_reg <= LAG_RESET;
        end
        else if (cfg_ch.valid)
        begin
            max_lag_reg <= cfg_ch.max_lag;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (prod_vld_reg && prod_last_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_done)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        in_ch.ready  = 1'b0;
        out_ch.valid = 1'b0;
        case (state_reg)
            ST_RUN:
            begin
                in_ch.ready = !(prod_vld_reg && prod_last_reg);
            end
            ST_DRAIN:
            begin
                out_ch.valid = 1'b1;
            end
            default:
            begin
                in_ch.ready  = 1'b0;
                out_ch.valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        lag_cnt_next = lag_cnt_reg;
        if (drain_done)
        begin
            lag_cnt_next = '0;
        end
        else if (out_fire)
        begin
            lag_cnt_next = lag_cnt_reg + LAG_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            lag_cnt_reg   <= '0;
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lag_cnt_reg   <= lag_cnt_next;
            prod_vld_reg  <= in_fire;
            prod_last_reg <= in_fire && in_ch.last_in;
        end
    end

    always_comb
    begin
        ctl.take  = in_fire;
        ctl.flush = in_fire && in_ch.last_in;
        ctl.accum = prod_vld_reg;
        ctl.shift = out_fire && !drain_done;
        ctl.clear = drain_done;
    end

    assign a_chain[0]           = in_ch.a_sample;
    assign b_chain[0]           = in_ch.b_sample;
    assign pos_chain[MAX_LAG+1] = '0;
    assign neg_chain[MAX_LAG+1] = '0;

    // Lag zero adds a*b to both banks.
    lcor_mac u_pos0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .x        (in_ch.a_sample),
        .y        (in_ch.b_sample),
        .shift_in (pos_chain[1]),
        .acc      (pos_chain[0])
    );

    lcor_mac u_neg0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .x        (in_ch.a_sample),
        .y        (in_ch.b_sample),
        .shift_in (neg_chain[1]),
        .acc      (neg_chain[0])
    );

    for (genvar k = 1; k <= MAX_LAG; k++)
    begin : g_cell
        lcor_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .a_cur   (in_ch.a_sample),
            .b_cur   (in_ch.b_sample),
            .a_in    (a_chain[k-1]),
            .b_in    (b_chain[k-1]),
            .a_out   (a_chain[k]),
            .b_out   (b_chain[k]),
            .pos_in  (pos_chain[k+1]),
            .neg_in  (neg_chain[k+1]),
            .pos_acc (pos_chain[k]),
            .neg_acc (neg_chain[k])
        );
    end

    assign out_ch.lag      = lag_cnt_reg;
    assign out_ch.pos_sum  = pos_chain[0];
    assign out_ch.neg_sum  = neg_chain[0];
    assign out_ch.last_out = (lag_cnt_reg == top_lag);

endmodule

@@ hw/rtl/lcor_mac.sv @@
// ----------------------------------------------------------------------------
// lcor_mac
// Registered multiply followed by a saturating 48-bit accumulate; the
// accumulator also shifts toward lag zero while results are unloaded.
// ----------------------------------------------------------------------------
module lcor_mac (
    input  logic              clk,
    input  logic              rst_n,
    input  lcor_pkg::ctl_t    ctl,
    input  lcor_pkg::sample_t x,
    input  lcor_pkg::sample_t y,
    input  lcor_pkg::acc_t    shift_in,
    output lcor_pkg::acc_t    acc
);
    import lcor_pkg::*;

    prod_t                    prod_reg;
    acc_t                     acc_reg;
    acc_t                     acc_next;
    logic signed [ACC_W:0]    sum;

    always_comb
    begin
        sum = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(prod_reg);
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (ctl.shift)
        begin
            acc_next = shift_in;
        end
        else if (ctl.accum)
        begin
            if (sum[ACC_W] != sum[ACC_W-1])
            begin
                acc_next = sum[ACC_W] ? ACC_MIN : ACC_MAX;
            end
            else
            begin
                acc_next = sum[ACC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            prod_reg <= x * y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

@@ hw/rtl/lcor_cell.sv @@
// ----------------------------------------------------------------------------
// lcor_cell
// One nonzero lag: holds one delayed sample of each sequence, passes it on
// to the next cell, and keeps the positive and negative lag sums.
// ----------------------------------------------------------------------------
module lcor_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  lcor_pkg::ctl_t    ctl,
    input  lcor_pkg::sample_t a_cur,
    input  lcor_pkg::sample_t b_cur,
    input  lcor_pkg::sample_t a_in,
    input  lcor_pkg::sample_t b_in,
    output lcor_pkg::sample_t a_out,
    output lcor_pkg::sample_t b_out,
    input  lcor_pkg::acc_t    pos_in,
    input  lcor_pkg::acc_t    neg_in,
    output lcor_pkg::acc_t    pos_acc,
    output lcor_pkg::acc_t    neg_acc
);
    import lcor_pkg::*;

    sample_t a_hist_reg;
    sample_t b_hist_reg;

    // The history is emptied with the final pair of a sequence.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_hist_reg <= '0;
            b_hist_reg <= '0;
        end
        else if (ctl.take)
        begin
            a_hist_reg <= ctl.flush ? '0 : a_in;
            b_hist_reg <= ctl.flush ? '0 : b_in;
        end
    end

    lcor_mac u_pos (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .x        (a_hist_reg),
        .y        (b_cur),
        .shift_in (pos_in),
        .acc      (pos_acc)
    );

    lcor_mac u_neg (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .x        (a_cur),
        .y        (b_hist_reg),
        .shift_in (neg_in),
        .acc      (neg_acc)
    );

    assign a_out = a_hist_reg;
    assign b_out = b_hist_reg;

endmodule
